/* hdl/salc_pkg.sv */
`timescale 1ns / 1ps

package salc_pkg;

   // default geometry
   localparam int MAX_SET_BITS_DEF = 8;
   localparam int MAX_WAYS_DEF     = 8;

   // field widths
   localparam int TAG_W    = 64;
   localparam int STAMP_W  = 64;
   localparam int TOTAL_W  = 32;
   localparam int ADDR_W   = 64;
   localparam int CMD_W    = 2;
   localparam int OUT_W    = 2;
   localparam int SB_W     = 4;
   localparam int BB_W     = 6;
   localparam int NW_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = 32'hffff_ffff;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;

   // outcome codes
   localparam logic [OUT_W-1:0] OUT_HIT   = 2'd0;
   localparam logic [OUT_W-1:0] OUT_MISS  = 2'd1;
   localparam logic [OUT_W-1:0] OUT_EVICT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   // register reset values
   localparam logic [SB_W-1:0] SET_BITS_RST   = 4'd4;
   localparam logic [BB_W-1:0] BLOCK_BITS_RST = 6'd4;
   localparam logic [NW_W-1:0] WAYS_RST       = 4'd1;

   // saturating increment of a running total
   function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
      return (v < TOTAL_LIMIT) ? v + TOTAL_W'(1) : v;
   endfunction

endpackage

/* hdl/set_assoc_lru_cache_sim.sv */
`timescale 1ns / 1ps

// Channel   Ports                                     Transaction
// -------   ---------------------------------------   ----------------------------
// request   start, busy, req_command, req_address     start high while busy low
// result    rsp_valid, rsp_outcome, rsp_last,         one cycle with rsp_valid high
//           rsp_hits, rsp_misses, rsp_evictions
// config    csr_valid, csr_ready, csr_index, csr_data csr_valid and csr_ready high
//
// A load or store passes from acceptance through the look and evaluate states; a
// modify evaluates twice. A miss with every used way valid adds the search state, a
// least-recently-used search which walks the stamps of the set one way a cycle.
// Each access reads one set row from the tag RAM through a registered read port and
// writes it back; the second access of a modify works on the held row.
// Reset clears the totals, the stamp counter and the per-set written flags, which
// make untouched sets read as empty. The receiver cannot stall results.

module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [salc_pkg::CMD_W-1:0]          req_command,
   input  logic [salc_pkg::ADDR_W-1:0]         req_address,
   // result
   output logic                                rsp_valid,
   output logic [salc_pkg::OUT_W-1:0]          rsp_outcome,
   output logic                                rsp_last,
   output logic [salc_pkg::TOTAL_W-1:0]        rsp_hits,
   output logic [salc_pkg::TOTAL_W-1:0]        rsp_misses,
   output logic [salc_pkg::TOTAL_W-1:0]        rsp_evictions,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [salc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DEPTH    = 1 << MAX_SET_BITS;
   localparam int SET_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W    = $clog2(MAX_WAYS + 1);
   localparam int TAG_W    = salc_pkg::TAG_W;
   localparam int STAMP_W  = salc_pkg::STAMP_W;
   localparam int WAY_BITS = 1 + TAG_W + STAMP_W;
   localparam int ROW_W    = MAX_WAYS * WAY_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EVAL,
      ST_SCAN
   } state_type;

   // control and payload registers
   state_type                        state_ff, state_in;
   logic [SET_W-1:0]                 set_ff, set_in;
   logic [TAG_W-1:0]                 tag_ff, tag_in;
   logic                             second_ff, second_in;
   logic                             row_valid_ff [MAX_WAYS];
   logic                             row_valid_in [MAX_WAYS];
   logic [TAG_W-1:0]                 row_tag_ff   [MAX_WAYS];
   logic [TAG_W-1:0]                 row_tag_in   [MAX_WAYS];
   logic [STAMP_W-1:0]               row_stamp_ff [MAX_WAYS];
   logic [STAMP_W-1:0]               row_stamp_in [MAX_WAYS];
   logic [WAY_W-1:0]                 victim_ff, victim_in;
   logic [STAMP_W-1:0]               best_ff, best_in;
   logic [CNT_W-1:0]                 scan_idx_ff, scan_idx_in;
   logic [STAMP_W-1:0]               stamp_ff, stamp_in;
   logic [salc_pkg::TOTAL_W-1:0]     hit_ff, hit_in;
   logic [salc_pkg::TOTAL_W-1:0]     miss_ff, miss_in;
   logic [salc_pkg::TOTAL_W-1:0]     evict_ff, evict_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [salc_pkg::OUT_W-1:0]       rsp_outcome_ff, rsp_outcome_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [salc_pkg::SB_W-1:0]        cfg_set_bits_ff, cfg_set_bits_in;
   logic [salc_pkg::BB_W-1:0]        cfg_block_bits_ff, cfg_block_bits_in;
   logic [salc_pkg::NW_W-1:0]        cfg_ways_ff, cfg_ways_in;
   logic [DEPTH-1:0]                 row_written_ff, row_written_in;

   // combinational helpers
   logic                             accept;
   logic                             csr_write;
   logic [salc_pkg::SB_W-1:0]        sb_eff;
   logic [CNT_W-1:0]                 nw_eff;
   logic [salc_pkg::ADDR_W-1:0]      shifted;
   logic [6:0]                       total_bits;
   logic [SET_W-1:0]                 set_mask;
   logic [SET_W-1:0]                 set_calc;
   logic [TAG_W-1:0]                 tag_calc;
   logic [MAX_WAYS-1:0]              hit_vec;
   logic [MAX_WAYS-1:0]              free_vec;
   logic                             any_hit;
   logic                             any_free;
   logic [WAY_W-1:0]                 hit_way;
   logic [WAY_W-1:0]                 free_way;
   logic [STAMP_W-1:0]               scan_stamp;
   logic                             upd_en;
   logic [WAY_W-1:0]                 upd_way;
   logic [salc_pkg::OUT_W-1:0]       upd_outcome;
   logic                             inc_hit;
   logic                             inc_miss;
   logic                             inc_evict;
   logic [ROW_W-1:0]                 ram_rd_data;
   logic [ROW_W-1:0]                 ram_wr_data;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;

   // clamp the set bits and the way count to the built geometry
   always_comb begin
      if (int'(cfg_set_bits_ff) > MAX_SET_BITS) begin
         sb_eff = salc_pkg::SB_W'(MAX_SET_BITS);
      end else begin
         sb_eff = cfg_set_bits_ff;
      end
      if (cfg_ways_ff == '0) begin
         nw_eff = CNT_W'(1);
      end else if (int'(cfg_ways_ff) > MAX_WAYS) begin
         nw_eff = CNT_W'(MAX_WAYS);
      end else begin
         nw_eff = CNT_W'(cfg_ways_ff);
      end
   end

   // split the request address into set index and tag
   always_comb begin
      shifted    = req_address >> cfg_block_bits_ff;
      total_bits = {1'b0, cfg_block_bits_ff} + {3'b000, sb_eff};
      for (int b = 0; b < SET_W; b++) begin
         set_mask[b] = (b < int'(sb_eff));
      end
      set_calc = shifted[SET_W-1:0] & set_mask;
      if (total_bits[6]) begin
         tag_calc = '0;
      end else begin
         tag_calc = req_address >> total_bits[5:0];
      end
   end

   // compare the held row against the tag
   always_comb begin
      any_hit  = 1'b0;
      any_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         hit_vec[w]  = (w < int'(nw_eff)) && row_valid_ff[w] && (row_tag_ff[w] == tag_ff);
         free_vec[w] = (w < int'(nw_eff)) && !row_valid_ff[w];
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            any_hit = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (free_vec[w]) begin
            any_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end
      scan_stamp = row_stamp_ff[scan_idx_ff[WAY_W-1:0]];
   end

   // pick the way to update and the outcome
   always_comb begin
      upd_en      = 1'b0;
      upd_way     = '0;
      upd_outcome = salc_pkg::OUT_HIT;
      inc_hit     = 1'b0;
      inc_miss    = 1'b0;
      inc_evict   = 1'b0;
      case (state_ff)
         ST_EVAL: begin
            if (any_hit) begin
               upd_en  = 1'b1;
               upd_way = hit_way;
               inc_hit = 1'b1;
            end else if (any_free) begin
               upd_en      = 1'b1;
               upd_way     = free_way;
               upd_outcome = salc_pkg::OUT_MISS;
               inc_miss    = 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == nw_eff) begin
               upd_en      = 1'b1;
               upd_way     = victim_ff;
               upd_outcome = salc_pkg::OUT_EVICT;
               inc_miss    = 1'b1;
               inc_evict   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // next state and registered outputs
   always_comb begin
      state_in          = state_ff;
      set_in            = set_ff;
      tag_in            = tag_ff;
      second_in         = second_ff;
      victim_in         = victim_ff;
      best_in           = best_ff;
      scan_idx_in       = scan_idx_ff;
      stamp_in          = stamp_ff;
      hit_in            = hit_ff;
      miss_in           = miss_ff;
      evict_in          = evict_ff;
      rsp_valid_in      = 1'b0;
      rsp_outcome_in    = rsp_outcome_ff;
      rsp_last_in       = rsp_last_ff;
      cfg_set_bits_in   = cfg_set_bits_ff;
      cfg_block_bits_in = cfg_block_bits_ff;
      cfg_ways_in       = cfg_ways_ff;
      row_written_in    = row_written_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         row_valid_in[w] = row_valid_ff[w];
         row_tag_in[w]   = row_tag_ff[w];
         row_stamp_in[w] = row_stamp_ff[w];
      end

      // configuration writes
      if (csr_write) begin
         case (csr_index)
            salc_pkg::CSR_SET_BITS:   cfg_set_bits_in   = csr_data[salc_pkg::SB_W-1:0];
            salc_pkg::CSR_BLOCK_BITS: cfg_block_bits_in = csr_data;
            salc_pkg::CSR_WAYS:       cfg_ways_in       = csr_data[salc_pkg::NW_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               set_in    = set_calc;
               tag_in    = tag_calc;
               second_in = (req_command == salc_pkg::CMD_MODIFY);
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // capture the row; a set never written reads as empty
            for (int w = 0; w < MAX_WAYS; w++) begin
               row_valid_in[w] = ram_rd_data[w*WAY_BITS + TAG_W + STAMP_W]
                                 && row_written_ff[set_ff];
               row_tag_in[w]   = ram_rd_data[w*WAY_BITS + STAMP_W +: TAG_W];
               row_stamp_in[w] = ram_rd_data[w*WAY_BITS +: STAMP_W];
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!upd_en) begin
               // all used ways valid: start the oldest-stamp search
               victim_in   = '0;
               best_in     = row_stamp_ff[0];
               scan_idx_in = CNT_W'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!upd_en) begin
               if (scan_stamp < best_ff) begin
                  victim_in = scan_idx_ff[WAY_W-1:0];
                  best_in   = scan_stamp;
               end
               scan_idx_in = scan_idx_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // update the chosen way, count and emit the transaction
      if (upd_en) begin
         row_valid_in[upd_way] = 1'b1;
         row_tag_in[upd_way]   = tag_ff;
         row_stamp_in[upd_way] = stamp_ff;
         stamp_in              = stamp_ff + STAMP_W'(1);
         row_written_in[set_ff] = 1'b1;
         if (inc_hit) begin
            hit_in = salc_pkg::bump(hit_ff);
         end
         if (inc_miss) begin
            miss_in = salc_pkg::bump(miss_ff);
         end
         if (inc_evict) begin
            evict_in = salc_pkg::bump(evict_ff);
         end
         rsp_valid_in   = 1'b1;
         rsp_outcome_in = upd_outcome;
         rsp_last_in    = !second_ff;
         if (second_ff) begin
            second_in = 1'b0;
            state_in  = ST_EVAL;
         end else begin
            state_in  = ST_IDLE;
         end
      end
   end

   // pack the updated row for write-back
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         ram_wr_data[w*WAY_BITS +: WAY_BITS] = {row_valid_in[w], row_tag_in[w],
                                                row_stamp_in[w]};
      end
   end

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (upd_en),
      .wr_addr (set_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (set_calc),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      // payload
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      victim_ff      <= victim_in;
      best_ff        <= best_in;
      scan_idx_ff    <= scan_idx_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_last_ff    <= rsp_last_in;
      for (int w = 0; w < MAX_WAYS; w++) begin
         row_valid_ff[w] <= row_valid_in[w];
         row_tag_ff[w]   <= row_tag_in[w];
         row_stamp_ff[w] <= row_stamp_in[w];
      end
      // control
      if (reset) begin
         state_ff          <= ST_IDLE;
         second_ff         <= 1'b0;
         stamp_ff          <= '0;
         hit_ff            <= '0;
         miss_ff           <= '0;
         evict_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         cfg_set_bits_ff   <= salc_pkg::SET_BITS_RST;
         cfg_block_bits_ff <= salc_pkg::BLOCK_BITS_RST;
         cfg_ways_ff       <= salc_pkg::WAYS_RST;
         row_written_ff    <= '0;
      end else begin
         state_ff          <= state_in;
         second_ff         <= second_in;
         stamp_ff          <= stamp_in;
         hit_ff            <= hit_in;
         miss_ff           <= miss_in;
         evict_ff          <= evict_in;
         rsp_valid_ff      <= rsp_valid_in;
         cfg_set_bits_ff   <= cfg_set_bits_in;
         cfg_block_bits_ff <= cfg_block_bits_in;
         cfg_ways_ff       <= cfg_ways_in;
         row_written_ff    <= row_written_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_hits      = hit_ff;
   assign rsp_misses    = miss_ff;
   assign rsp_evictions = evict_ff;

`ifndef SYNTHESIS
   // the final result of a transaction leaves the block idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result while still busy");

   // the first result of a modify keeps the block busy for the second access
   a_first_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("first result of a modify while idle");

   // leaving busy always comes with the final result
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid && rsp_last)
      else $error("transaction ended without final result");

   // every eviction is also a miss
   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      evict_ff <= miss_ff)
      else $error("eviction total above miss total");

   // the search never runs past the used ways
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_idx_ff <= nw_eff)
      else $error("way search ran past the used ways");
`endif

endmodule

/* hdl/salc_ram.sv */
`timescale 1ns / 1ps

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
